@@ rtl/core/pbd_pkg.sv @@
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared widths, reset levels, register codes and control types of the
// pulse beat detector.
// ----------------------------------------------------------------------------
package pbd_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int TICK_W     = 4;
  localparam int GAP_W      = 12;
  localparam int TMO_W      = 13;
  localparam int TIME_W     = 16;
  localparam int RATE_W     = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [SAMPLE_W-1:0] LEVEL_RST    = SAMPLE_W'(520);
  localparam logic [SAMPLE_W-1:0] LEVEL_MAX    = SAMPLE_W'(1023);
  localparam logic [TIME_W-1:0]   INTERVAL_RST = TIME_W'(600);
  localparam logic [TIME_W-1:0]   GATE_RST     = TIME_W'((600 / 5) * 3);
  localparam logic [TIME_W-1:0]   ELAPSED_MAX  = TIME_W'(65535);
  localparam logic [RATE_W-1:0]   MS_PER_MIN   = RATE_W'(60000);

  localparam logic [TICK_W-1:0]   TICK_RST     = TICK_W'(2);
  localparam logic [GAP_W-1:0]    GAP_RST      = GAP_W'(250);
  localparam logic [TMO_W-1:0]    TMO_RST      = TMO_W'(2500);
  localparam logic [SAMPLE_W-1:0] REARM_RST    = SAMPLE_W'(512);

  // x / 5 == (x * 52429) >> 18 for every 16-bit x
  localparam logic [TIME_W:0]     DIV5_RECIP   = 17'd52429;
  localparam int                  DIV5_SHIFT   = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK  = 4'd0,
    CFG_GAP   = 4'd1,
    CFG_TMO   = 4'd2,
    CFG_REARM = 4'd3
  } pbd_cfg_idx_t;

  typedef struct packed {
    logic load;       // capture the accepted sample
    logic eval;       // run the detection step
    logic hist;       // update history and running sum
    logic div_start;  // launch the rate divider
    logic mean_cap;   // take the mean of the history
    logic rate_cap;   // take the rate from the divider
    logic out_load;   // load the result register
  } pbd_cmd_t;

  typedef struct packed {
    logic beat;       // the sample under evaluation declares a beat
    logic div_busy;   // divider still iterating
  } pbd_sts_t;

endpackage

@@ rtl/core/pbd_ifs.sv @@
// ----------------------------------------------------------------------------
// pbd_ifs
// Sample, result and configuration channels of the pulse beat detector.
// ----------------------------------------------------------------------------
interface pbd_in_if;
  import pbd_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface pbd_out_if;
  import pbd_pkg::*;
  logic                valid;
  logic                ready;
  logic                beat;
  logic [RATE_W-1:0]   bpm;
  logic [TIME_W-1:0]   beat_interval_ms;
  logic                in_pulse;
  logic [SAMPLE_W-1:0] threshold_level;
  modport source (output valid, output beat, output bpm, output beat_interval_ms,
                  output in_pulse, output threshold_level, input ready);
  modport sink   (input valid, input beat, input bpm, input beat_interval_ms,
                  input in_pulse, input threshold_level, output ready);
endinterface

interface pbd_cfg_if;
  import pbd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/pbd_divider.sv @@
// ----------------------------------------------------------------------------
// pbd_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbd_divider #(
  parameter int W = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     den_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W:0]       trial;

  always_comb begin
    trial = {rem_r, quo_r[W-1]} - {1'b0, den_r};
    if (!trial[W]) begin
      rem_nxt = trial[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
      quo_nxt = {quo_r[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

@@ rtl/core/pbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// pbd_ctrl
// Sequencer of the beat detector: accepts a sample, steps the datapath
// through evaluation and, on a beat, history update, the mean and the rate
// division, then hands the result to the output register.
// ----------------------------------------------------------------------------
module pbd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pbd_pkg::pbd_sts_t sts,
  output pbd_pkg::pbd_cmd_t cmd
);
  import pbd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_HIST,
    ST_MEAN,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.beat ? ST_HIST : ST_OUT;
      end
      ST_HIST: begin
        cmd.hist  = 1'b1;
        state_nxt = ST_MEAN;
      end
      ST_MEAN: begin
        cmd.mean_cap = 1'b1;
        state_nxt    = ST_RATE_GO;
      end
      ST_RATE_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (!sts.div_busy) begin
          cmd.rate_cap = 1'b1;
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/pbd_datapath.sv @@
// ----------------------------------------------------------------------------
// pbd_datapath
// Detection state, configuration registers, interval history with a
// running sum, the rate divider and the result register.
// ----------------------------------------------------------------------------
module pbd_datapath #(
  parameter int HISTORY_DEPTH = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pbd_pkg::pbd_cmd_t              cmd,
  output pbd_pkg::pbd_sts_t              sts,
  input  logic                           cfg_we,
  input  logic [pbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [pbd_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                           out_beat,
  output logic [pbd_pkg::RATE_W-1:0]     out_bpm,
  output logic [pbd_pkg::TIME_W-1:0]     out_interval,
  output logic                           out_in_pulse,
  output logic [pbd_pkg::SAMPLE_W-1:0]   out_threshold
);
  import pbd_pkg::*;

  localparam int PTR_W  = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = TIME_W + $clog2(HISTORY_DEPTH);
  localparam int LVL_SW = SAMPLE_W + 2;

  // sum / HISTORY_DEPTH == (sum * MEAN_RECIP) >> MEAN_SHIFT for every SUM_W-bit sum
  localparam int MEAN_SHIFT = SUM_W + $clog2(HISTORY_DEPTH);
  localparam int REC_W      = SUM_W + 2;
  localparam logic [REC_W-1:0] MEAN_RECIP =
    REC_W'(((64'd1 << MEAN_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

  // configuration
  logic [TICK_W-1:0]   tick_r;
  logic [GAP_W-1:0]    gap_r;
  logic [TMO_W-1:0]    tmo_r;
  logic [SAMPLE_W-1:0] rearm_r;

  // detection state
  logic [TIME_W-1:0]   elapsed_r;
  logic [SAMPLE_W-1:0] peak_r, trough_r, thr_r;
  logic [TIME_W-1:0]   interval_r, gate_r;
  logic [RATE_W-1:0]   rate_r;
  logic                pulse_r, needs_seed_r;

  // per-sample working registers
  logic [SAMPLE_W-1:0] sample_r;
  logic [TIME_W-1:0]   n_r;
  logic                beat_r, seed_r;

  // history
  logic [TIME_W-1:0]   hist_mem [HISTORY_DEPTH];
  logic [TIME_W-1:0]   oldest_r;
  logic [TIME_W-1:0]   seed_val_r;
  logic [PTR_W-1:0]    wp_r;
  logic [FILL_W-1:0]   fill_r;
  logic [SUM_W-1:0]    sum_r;
  logic [TIME_W-1:0]   mean_r;
  logic [SUM_W+REC_W-1:0] mean_prod;
  logic [TIME_W-1:0]   mean_q;

  // divider
  logic [SUM_W-1:0]    div_dividend, div_divisor, div_quo;
  logic                div_busy;

  // combinational step values
  logic [TIME_W:0]     elapsed_add;
  logic [TIME_W-1:0]   n_nxt;
  logic                below, above, past_gate, beat_now, pulse_end, timeout;
  logic [SAMPLE_W-1:0] peak_a, trough_a;
  logic signed [LVL_SW-1:0] amp, half, t_lvl;
  logic [SAMPLE_W-1:0] t_clamp;
  logic [TIME_W-1:0]   oldest;
  logic [2*TIME_W+1:0] gate_prod;
  logic [TIME_W-1:0]   gate_q, gate_nxt;

  // elapsed time, saturating
  assign elapsed_add = {1'b0, elapsed_r} + (TIME_W+1)'(tick_r);
  assign n_nxt       = elapsed_add[TIME_W] ? ELAPSED_MAX : elapsed_add[TIME_W-1:0];

  always_comb begin
    below     = sample_r < thr_r;
    above     = sample_r > thr_r;
    past_gate = n_r > gate_r;
    beat_now  = (n_r > TIME_W'(gap_r)) && above && !pulse_r && past_gate;
    timeout   = n_r > TIME_W'(tmo_r);
    trough_a  = (below && past_gate && (sample_r < trough_r)) ? sample_r : trough_r;
    peak_a    = (above && (sample_r > peak_r)) ? sample_r : peak_r;
    pulse_end = below && pulse_r;
    amp       = LVL_SW'(signed'({1'b0, peak_a})) - LVL_SW'(signed'({1'b0, trough_a}));
    // halve toward zero
    half      = (amp + LVL_SW'(signed'({1'b0, amp[LVL_SW-1]}))) >>> 1;
    t_lvl     = half + LVL_SW'(signed'({1'b0, trough_a}));
    if (t_lvl < 0) begin
      t_clamp = '0;
    end else if (t_lvl > LVL_SW'(signed'({1'b0, LEVEL_MAX}))) begin
      t_clamp = LEVEL_MAX;
    end else begin
      t_clamp = t_lvl[SAMPLE_W-1:0];
    end
  end

  assign sts = {beat_now, div_busy};

  // next gate = (interval / 5) * 3
  assign gate_prod = (2*TIME_W+2)'(interval_r) * (2*TIME_W+2)'(DIV5_RECIP);
  assign gate_q    = TIME_W'(gate_prod >> DIV5_SHIFT);
  assign gate_nxt  = {gate_q[TIME_W-2:0], 1'b0} + gate_q;

  // history mean by reciprocal multiply
  assign mean_prod = (SUM_W+REC_W)'(sum_r) * (SUM_W+REC_W)'(MEAN_RECIP);
  assign mean_q    = TIME_W'(mean_prod >> MEAN_SHIFT);

  // entries not rewritten since the last seed read as the seed value
  assign oldest = (fill_r < FILL_W'(HISTORY_DEPTH)) ? seed_val_r : oldest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= TICK_RST;
      gap_r   <= GAP_RST;
      tmo_r   <= TMO_RST;
      rearm_r <= REARM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK:  tick_r  <= cfg_data[TICK_W-1:0];
        CFG_GAP:   gap_r   <= cfg_data[GAP_W-1:0];
        CFG_TMO:   tmo_r   <= cfg_data[TMO_W-1:0];
        CFG_REARM: rearm_r <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r    <= '0;
      peak_r       <= LEVEL_RST;
      trough_r     <= LEVEL_RST;
      thr_r        <= LEVEL_RST;
      interval_r   <= INTERVAL_RST;
      gate_r       <= GATE_RST;
      rate_r       <= '0;
      pulse_r      <= 1'b0;
      needs_seed_r <= 1'b1;
      wp_r         <= '0;
      fill_r       <= '0;
    end else begin
      if (cmd.eval) begin
        peak_r   <= peak_a;
        trough_r <= trough_a;
        elapsed_r <= (beat_now || timeout) ? '0 : n_r;
        if (beat_now) begin
          pulse_r      <= 1'b1;
          interval_r   <= n_r;
          needs_seed_r <= 1'b0;
        end
        if (pulse_end) begin
          pulse_r  <= 1'b0;
          thr_r    <= t_clamp;
          peak_r   <= t_clamp;
          trough_r <= t_clamp;
        end
        if (timeout) begin
          thr_r        <= rearm_r;
          peak_r       <= rearm_r;
          trough_r     <= rearm_r;
          needs_seed_r <= 1'b1;
        end
      end
      if (cmd.hist) begin
        gate_r <= gate_nxt;
        if (seed_r) begin
          fill_r <= '0;
        end else begin
          wp_r   <= (wp_r == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
          if (fill_r < FILL_W'(HISTORY_DEPTH)) begin
            fill_r <= fill_r + 1'b1;
          end
        end
      end
      if (cmd.rate_cap) begin
        rate_r <= (mean_r == '0) ? MS_PER_MIN : div_quo[RATE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
      n_r      <= n_nxt;
    end
    if (cmd.eval) begin
      beat_r   <= beat_now;
      seed_r   <= needs_seed_r;
      oldest_r <= hist_mem[wp_r];
    end
    if (cmd.hist) begin
      if (seed_r) begin
        seed_val_r <= interval_r;
        sum_r      <= SUM_W'(interval_r) * SUM_W'(HISTORY_DEPTH);
      end else begin
        hist_mem[wp_r] <= interval_r;
        sum_r          <= sum_r - SUM_W'(oldest) + SUM_W'(interval_r);
      end
    end
    if (cmd.mean_cap) begin
      mean_r <= mean_q;
    end
    if (cmd.out_load) begin
      out_beat      <= beat_r;
      out_bpm       <= rate_r;
      out_interval  <= interval_r;
      out_in_pulse  <= pulse_r;
      out_threshold <= thr_r;
    end
  end

  assign div_dividend = SUM_W'(MS_PER_MIN);
  assign div_divisor  = SUM_W'(mean_r);

  pbd_divider #(
    .W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

endmodule

@@ rtl/core/pulse_beat_detector.sv @@
// ----------------------------------------------------------------------------
// pulse_beat_detector
// Beat and rate detection for a ten-bit pulse sensor stream.
// ----------------------------------------------------------------------------
// Usage: one sample transfer on in_ch yields exactly one result transfer on
// out_ch (beat flag, bpm, last interval, pulse flag, threshold). Both use a
// valid/ready handshake. cfg_ch writes tick_ms, min_beat_gap_ms,
// silence_timeout_ms and rearm_level at indexes 0..3; cfg_ch.ready is
// always high and writes beyond the list are dropped. Write it only while
// no sample is in flight.
// Sequence: a sample without a beat is evaluated and its result loaded into
// the result register; the next sample can transfer as soon as that result
// is valid. A beat sample also updates the history, takes the mean by a
// reciprocal multiply and runs 60000 / mean on a restoring divider, one
// quotient bit per cycle over 16 + clog2(HISTORY_DEPTH) bits, before its
// result is loaded and the next sample can transfer.
// One sample is in work at a time; in_ch.ready is high only between samples.
// The result register lets the next sample enter while out_ch stalls; the
// sequencer then holds that sample's result until out_ch takes the previous.
// Reset (synchronous, active low) restores all configuration and detection
// state to their defaults and empties the result register.
// ----------------------------------------------------------------------------
module pulse_beat_detector #(
  parameter int HISTORY_DEPTH = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  pbd_in_if.sink    in_ch,
  pbd_out_if.source out_ch,
  pbd_cfg_if.sink   cfg_ch
);
  import pbd_pkg::*;

  pbd_cmd_t cmd;
  pbd_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  pbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pbd_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .in_sample     (in_ch.sample),
    .out_beat      (out_ch.beat),
    .out_bpm       (out_ch.bpm),
    .out_interval  (out_ch.beat_interval_ms),
    .out_in_pulse  (out_ch.in_pulse),
    .out_threshold (out_ch.threshold_level)
  );

endmodule

@@ bench/pbd_beat_check.sv @@
// ----------------------------------------------------------------------------
// pbd_beat_check
// Watches the sample, result and register channels of the pulse beat
// detector. Every sample transfer runs through a local copy of the detection
// algorithm. Every result transfer is compared with the oldest pending report.
// ----------------------------------------------------------------------------
module pbd_beat_check #(
  parameter int HISTORY_DEPTH = 10
) (
  input  logic clk,
  input  logic rst_n,
  pbd_in_if    in_ch,
  pbd_out_if   out_ch,
  pbd_cfg_if   cfg_ch,
  output int   fail_total,
  output int   awaiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import pbd_pkg::*;

  typedef struct packed {
    logic                beat;
    logic [RATE_W-1:0]   bpm;
    logic [TIME_W-1:0]   interval;
    logic                in_pulse;
    logic [SAMPLE_W-1:0] threshold;
  } beat_report_t;

  // register copies
  int unsigned tick_ms, min_gap_ms, timeout_ms, rearm_lvl;

  // detection state
  int unsigned elapsed_ms, interval_ms, rate_bpm;
  int          peak_lvl, trough_lvl, thresh_lvl;
  bit          pulse_on, needs_seed;
  int unsigned interval_hist [HISTORY_DEPTH];

  beat_report_t beat_reports [$];
  int           errors = 0;

  assign fail_total = errors;

  task automatic detect_beat_step(input logic [SAMPLE_W-1:0] s, output beat_report_t r);
    int          lvl, mid;
    int unsigned n, beat_gate, sum, mean;
    bit          beat;
    lvl  = int'(s);
    beat = 1'b0;
    elapsed_ms = elapsed_ms + tick_ms;
    if (elapsed_ms > 65535) elapsed_ms = 65535;
    n = elapsed_ms;
    beat_gate = (interval_ms / 5) * 3;

    if (lvl < thresh_lvl && n > beat_gate && lvl < trough_lvl) trough_lvl = lvl;
    if (lvl > thresh_lvl && lvl > peak_lvl) peak_lvl = lvl;

    if (n > min_gap_ms && lvl > thresh_lvl && !pulse_on && n > beat_gate) begin
      beat        = 1'b1;
      pulse_on    = 1'b1;
      interval_ms = n;
      elapsed_ms  = 0;
      if (needs_seed) begin
        needs_seed = 1'b0;
        foreach (interval_hist[i]) interval_hist[i] = interval_ms;
      end
      sum = 0;
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        interval_hist[i] = interval_hist[i + 1];
        sum += interval_hist[i];
      end
      interval_hist[HISTORY_DEPTH - 1] = interval_ms;
      sum += interval_ms;
      mean = sum / HISTORY_DEPTH;
      rate_bpm = (mean == 0) ? 60000 : 60000 / mean;
    end

    // pulse end: re-center the threshold between trough and peak
    if (lvl < thresh_lvl && pulse_on) begin
      mid = (peak_lvl - trough_lvl) / 2 + trough_lvl;
      if (mid < 0) mid = 0;
      if (mid > int'(LEVEL_MAX)) mid = int'(LEVEL_MAX);
      pulse_on   = 1'b0;
      thresh_lvl = mid;
      peak_lvl   = mid;
      trough_lvl = mid;
    end

    if (n > timeout_ms) begin
      thresh_lvl = int'(rearm_lvl);
      peak_lvl   = int'(rearm_lvl);
      trough_lvl = int'(rearm_lvl);
      elapsed_ms = 0;
      needs_seed = 1'b1;
    end

    r.beat      = beat;
    r.bpm       = RATE_W'(rate_bpm);
    r.interval  = TIME_W'(interval_ms);
    r.in_pulse  = pulse_on;
    r.threshold = SAMPLE_W'(thresh_lvl);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    beat_report_t due, seen;
    if (!rst_n) begin
      tick_ms     = TICK_RST;
      min_gap_ms  = GAP_RST;
      timeout_ms  = TMO_RST;
      rearm_lvl   = REARM_RST;
      elapsed_ms  = 0;
      peak_lvl    = int'(LEVEL_RST);
      trough_lvl  = int'(LEVEL_RST);
      thresh_lvl  = int'(LEVEL_RST);
      interval_ms = INTERVAL_RST;
      rate_bpm    = 0;
      pulse_on    = 1'b0;
      needs_seed  = 1'b1;
      foreach (interval_hist[i]) interval_hist[i] = 0;
      beat_reports.delete();
    end else begin
      // results never leave in the cycle their sample enters, so check first
      if (out_ch.valid && out_ch.ready) begin
        if (beat_reports.size() == 0) begin
          $error("result transfer with no sample pending");
          errors++;
        end else begin
          due = beat_reports.pop_front();
          seen.beat      = out_ch.beat;
          seen.bpm       = out_ch.bpm;
          seen.interval  = out_ch.beat_interval_ms;
          seen.in_pulse  = out_ch.in_pulse;
          seen.threshold = out_ch.threshold_level;
          compare_field("beat", due.beat, seen.beat);
          compare_field("bpm", due.bpm, seen.bpm);
          compare_field("beat_interval_ms", due.interval, seen.interval);
          compare_field("in_pulse", due.in_pulse, seen.in_pulse);
          compare_field("threshold_level", due.threshold, seen.threshold);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_TICK:  tick_ms    = cfg_ch.data[TICK_W-1:0];
          CFG_GAP:   min_gap_ms = cfg_ch.data[GAP_W-1:0];
          CFG_TMO:   timeout_ms = cfg_ch.data[TMO_W-1:0];
          CFG_REARM: rearm_lvl  = cfg_ch.data[SAMPLE_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        detect_beat_step(in_ch.sample, due);
        beat_reports.push_back(due);
      end
    end
    awaiting <= beat_reports.size();
  end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the pulse beat detector with directed extremes, then phases of
// synthetic heartbeat waveforms mixed with noise under several register
// settings, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pbd_pkg::*;

  localparam int          HISTORY_DEPTH = 10;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int          STALL_CYCLES  = 400;
  localparam int          DRAIN_CYCLES  = 64;
  localparam int          IDLE_PCT      = 9;

  logic clk;
  logic rst_n;
  bit   quiet;       // no idling on either side
  bit   hold_phase;  // receiver takes one long hold-off
  int   fail_total;
  int   awaiting;

  pbd_in_if  in_ch ();
  pbd_out_if out_ch ();
  pbd_cfg_if cfg_ch ();

  pulse_beat_detector #(.HISTORY_DEPTH(HISTORY_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pbd_beat_check #(.HISTORY_DEPTH(HISTORY_DEPTH)) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_total (fail_total),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[pulse_beat_detector] ERROR");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off
  initial begin : sink_side
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && hold_phase && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        for (int i = 0; i < STALL_CYCLES; i++) @(posedge clk);
      end else begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // drop valid and wait until every pending report has been checked
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  task automatic program_regs(input int unsigned tick, gap, tmo, rearm,
                              input logic [CFG_IDX_W-1:0] stray);
    logic [CFG_IDX_W-1:0] idx [5];
    int unsigned          val [5];
    int                   w   [5];
    idx[0] = CFG_TICK;  val[0] = tick;     w[0] = TICK_W;
    idx[1] = CFG_GAP;   val[1] = gap;      w[1] = GAP_W;
    idx[2] = CFG_TMO;   val[2] = tmo;      w[2] = TMO_W;
    idx[3] = CFG_REARM; val[3] = rearm;    w[3] = SAMPLE_W;
    idx[4] = stray;     val[4] = $urandom; w[4] = 0;
    for (int i = 0; i < 5; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      // junk above the register width must be dropped
      cfg_ch.data  <= CFG_DATA_W'(val[i] | ($urandom << w[i]));
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // pulse trains of random period, duty and levels, with some noise samples
  task automatic run_heartbeats(input int count);
    int left, period, width, hi, lo, lvl;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        push_sample(SAMPLE_W'($urandom_range(0, int'(LEVEL_MAX))));
        left--;
      end else begin
        period = $urandom_range(6, 70);
        width  = $urandom_range(1, period / 3);
        hi     = $urandom_range(560, int'(LEVEL_MAX));
        lo     = $urandom_range(0, 480);
        for (int k = 0; k < period && left > 0; k++) begin
          lvl = (k < width) ? hi : lo;
          lvl = lvl + int'($urandom_range(0, 30)) - 15;
          if (lvl < 0) lvl = 0;
          if (lvl > int'(LEVEL_MAX)) lvl = int'(LEVEL_MAX);
          push_sample(SAMPLE_W'(lvl));
          left--;
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [SAMPLE_W-1:0] opening [24];
    logic [CFG_IDX_W-1:0] stray;
    int unsigned tick, gap, tmo, rearm;
    int count;
    opening = '{10'd0, 10'd1023, 10'd1023, 10'd0, 10'd520, 10'd521, 10'd519, 10'd520,
                10'h155, 10'h2AA, 10'd1023, 10'd0, 10'd1023, 10'd1, 10'd1022, 10'd0,
                10'd512, 10'd513, 10'd511, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'd1023};
    quiet        = 1'b0;
    hold_phase   = 1'b0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes and threshold edges at the reset settings
    foreach (opening[i]) push_sample(opening[i]);
    settle();

    for (int ph = 1; ph <= 9; ph++) begin
      case (ph)
        1: begin tick = 15; gap = 250;  tmo = 2500; rearm = 512;  count = 300; end
        // timeout every sample, lowest re-arm level
        2: begin tick = 1;  gap = 0;    tmo = 0;    rearm = 0;    count = 120; end
        3: begin tick = 15; gap = 4095; tmo = 8191; rearm = 1023; count = 150; end
        // elapsed time frozen
        4: begin tick = 0;  gap = 0;    tmo = 8191; rearm = 512;  count = 60;  end
        5: begin tick = 8;  gap = 250;  tmo = 2500; rearm = 512;  count = 300; end
        default: begin
          tick  = $urandom_range(1, 15);
          gap   = $urandom_range(0, 400);
          tmo   = $urandom_range(600, 8191);
          rearm = $urandom_range(0, int'(LEVEL_MAX));
          count = 200;
        end
      endcase
      stray = (ph == 1) ? '1 : CFG_IDX_W'($urandom_range(int'(CFG_REARM) + 1,
                                                       (1 << CFG_IDX_W) - 1));
      program_regs(tick, gap, tmo, rearm, stray);
      quiet      = (ph == 5);
      hold_phase = (ph == 2);
      run_heartbeats(count);
      settle();
    end
    quiet = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_total == 0) begin
      $display("[pulse_beat_detector] OK");
    end else begin
      $display("[pulse_beat_detector] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pbd_pkg.sv
rtl/core/pbd_ifs.sv
rtl/core/pbd_divider.sv
rtl/core/pbd_ctrl.sv
rtl/core/pbd_datapath.sv
rtl/core/pulse_beat_detector.sv
bench/pbd_beat_check.sv
bench/testbench.sv
